/* sv/otmt_pkg.sv */
// ----------------------------------------------------------------------------
// otmt_pkg: shared types and constants of the one-shot timer table
// Holds the channel payload structs, the work item that travels from the
// front end to the back end, the operation and status codes, and the states
// of the back end sequencer.
// ----------------------------------------------------------------------------
package otmt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NFOUND_W    = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 32;
    localparam int ID_W        = 4;
    localparam int TIMEOUT_W   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_ARM  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_ARM  = 1'b0,
        KIND_FIRE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BAD_ID = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_REJECT = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_COMMIT = 2'd2,
        S_FLUSH  = 2'd3
    } t_state;

    typedef struct packed {
        logic                 command;
        logic [ID_W-1:0]      client_id;
        logic [TIMEOUT_W-1:0] timeout;
    } t_in_item;

    typedef struct packed {
        logic            kind;
        logic [1:0]      status;
        logic [ID_W-1:0] fired_id;
        logic            last;
    } t_out_item;

    typedef struct packed {
        t_op                  op;
        logic [ID_W-1:0]      client_id;
        logic [TIMEOUT_W-1:0] timeout;
    } t_work;

endpackage

/* sv/otmt_front.sv */
// ----------------------------------------------------------------------------
// otmt_front: command intake and work queue
// Accepts input transfers, classifies each command as arm, rejected arm or
// tick, and holds the work items in a short queue for the back end.
// ----------------------------------------------------------------------------
module otmt_front
    import otmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    output logic     o_q_valid,
    output t_work    o_q_item,
    input  logic     i_q_pop
);

    t_work              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic               accept;
    logic               pop;
    t_work              item;

    assign o_stall   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rd];

    always_comb begin
        item.client_id = i_data.client_id;
        item.timeout   = i_data.timeout;
        if (i_data.command == CMD_TICK) begin
            item.op = OP_TICK;
        end else if (i_data.client_id == '0) begin
            item.op = OP_REJECT;
        end else begin
            item.op = OP_ARM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({accept, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/otmt_back.sv */
// ----------------------------------------------------------------------------
// otmt_back: slot table and scan sequencer
// Executes one work item at a time. Owners and deadlines live in memories
// that are scanned one slot per cycle unless a held result stalls the scan;
// armed and used flags are flops. An arm writes its chosen slot after the
// scan; a tick reports expired slots in slot order via the output register.
// ----------------------------------------------------------------------------
module otmt_back
    import otmt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_work     i_q_item,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [ID_W-1:0]   owner_mem [SLOTS];
    logic [TIME_W-1:0] dl_mem    [SLOTS];

    t_state              r_state, n_state;
    t_work               r_cur, n_cur;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [SLOTS-1:0]    r_armed, n_armed;
    logic [SLOTS-1:0]    r_used, n_used;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_chk_vld, n_chk_vld;
    logic [IW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_match_found, n_match_found;
    logic [IW-1:0]       r_match_idx, n_match_idx;
    logic                r_free_found, n_free_found;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic                r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [NFOUND_W-1:0] r_nfound, n_nfound;
    logic                r_out_vld;
    t_out_item           r_out;
    logic [ID_W-1:0]     r_rd_owner;
    logic [TIME_W-1:0]   r_rd_dl;

    logic              out_free;
    logic              issue;
    logic [IW-1:0]     rd_addr;
    logic              adv;
    logic              is_tick;
    logic [TIME_W-1:0] diff;
    logic              hit;
    logic              own_hit;
    logic              free_hit;
    logic              emit;
    t_out_item         emit_item;
    logic              mem_we;
    logic [IW-1:0]     wr_idx;

    assign out_free = !r_out_vld || !i_stall;
    assign issue    = (r_cnt < CW'(SLOTS));
    assign rd_addr  = issue ? r_cnt[IW-1:0] : '0;
    assign is_tick  = (r_cur.op == OP_TICK);
    assign diff     = r_time - r_rd_dl;
    assign hit      = is_tick && r_chk_vld && r_armed[r_chk_idx] && !diff[TIME_W-1]
                      && (r_nfound < NFOUND_W'(MAX_RESULTS));
    assign own_hit  = r_chk_vld && r_used[r_chk_idx] && !r_match_found
                      && (r_rd_owner == r_cur.client_id);
    assign free_hit = r_chk_vld && !r_armed[r_chk_idx] && !r_free_found;

    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_time        = r_time;
        n_armed       = r_armed;
        n_used        = r_used;
        n_cnt         = r_cnt;
        n_chk_vld     = r_chk_vld;
        n_chk_idx     = r_chk_idx;
        n_match_found = r_match_found;
        n_match_idx   = r_match_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_pend_vld    = r_pend_vld;
        n_pend_id     = r_pend_id;
        n_nfound      = r_nfound;
        o_q_pop       = 1'b0;
        adv           = 1'b0;
        emit          = 1'b0;
        emit_item     = '0;
        mem_we        = 1'b0;
        wr_idx        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && (i_q_item.op != OP_REJECT || out_free)) begin
                    o_q_pop       = 1'b1;
                    n_cur         = i_q_item;
                    n_cnt         = '0;
                    n_chk_vld     = 1'b0;
                    n_match_found = 1'b0;
                    n_free_found  = 1'b0;
                    n_pend_vld    = 1'b0;
                    n_nfound      = '0;
                    unique case (i_q_item.op)
                        OP_REJECT: begin
                            emit             = 1'b1;
                            emit_item.kind   = KIND_ARM;
                            emit_item.status = STAT_BAD_ID;
                            emit_item.last   = 1'b1;
                        end
                        OP_TICK: begin
                            n_time  = r_time + TIME_W'(1);
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!(hit && r_pend_vld && !out_free)) begin
                    adv = 1'b1;
                    if (is_tick) begin
                        if (hit) begin
                            if (r_pend_vld) begin
                                emit               = 1'b1;
                                emit_item.kind     = KIND_FIRE;
                                emit_item.status   = STAT_OK;
                                emit_item.fired_id = r_pend_id;
                                emit_item.last     = 1'b0;
                            end
                            n_pend_vld          = 1'b1;
                            n_pend_id           = r_rd_owner;
                            n_nfound            = r_nfound + NFOUND_W'(1);
                            n_armed[r_chk_idx]  = 1'b0;
                        end
                    end else begin
                        if (own_hit) begin
                            n_match_found = 1'b1;
                            n_match_idx   = r_chk_idx;
                        end
                        if (free_hit) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_chk_idx;
                        end
                    end
                    n_chk_vld = issue;
                    n_chk_idx = rd_addr;
                    if (issue) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_state = is_tick ? S_FLUSH : S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_item.kind = KIND_ARM;
                    emit_item.last = 1'b1;
                    n_state        = S_IDLE;
                    if (r_match_found || r_free_found) begin
                        emit_item.status = STAT_OK;
                        mem_we           = 1'b1;
                        wr_idx           = r_match_found ? r_match_idx : r_free_idx;
                        n_armed[wr_idx]  = 1'b1;
                        n_used[wr_idx]   = 1'b1;
                    end else begin
                        emit_item.status = STAT_FULL;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    emit               = 1'b1;
                    emit_item.kind     = KIND_FIRE;
                    emit_item.status   = STAT_OK;
                    emit_item.fired_id = r_pend_id;
                    emit_item.last     = 1'b1;
                    n_pend_vld         = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            owner_mem[wr_idx] <= r_cur.client_id;
            dl_mem[wr_idx]    <= r_time + TIME_W'(r_cur.timeout);
        end
        if (adv) begin
            r_rd_owner <= owner_mem[rd_addr];
            r_rd_dl    <= dl_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_time     <= '0;
            r_armed    <= '0;
            r_used     <= '0;
            r_cnt      <= '0;
            r_chk_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nfound   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_time     <= n_time;
            r_armed    <= n_armed;
            r_used     <= n_used;
            r_cnt      <= n_cnt;
            r_chk_vld  <= n_chk_vld;
            r_pend_vld <= n_pend_vld;
            r_nfound   <= n_nfound;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_chk_idx     <= n_chk_idx;
        r_match_found <= n_match_found;
        r_match_idx   <= n_match_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_pend_id     <= n_pend_id;
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_armed_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & ~r_used) == '0)
        else $error("armed slot without a written owner");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_COMMIT) |-> !r_pend_vld)
        else $error("pending expiry outside a tick");

    a_nfound_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfound <= NFOUND_W'(MAX_RESULTS))
        else $error("too many expiries in one tick");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !adv) |-> (r_pend_vld && r_out_vld && i_stall))
        else $error("scan held without a blocked result");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overwrote a waiting result");
`endif

endmodule

/* sv/one_shot_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_table_unit: table of one-shot timers keyed by client id
// Arm commands set a deadline for a client id; tick commands advance time
// and report expired timers in slot order, up to MAX_RESULTS per tick.
//
//   port group             dir   flow control     payload
//   i_valid/o_stall/i_data in    o_stall high     t_in_item
//   o_valid/i_stall/o_data out   i_stall high     t_out_item
//
// An arm with a nonzero id and a tick each scan the owner and deadline
// memories one slot per cycle, unless a result held by i_stall holds the
// scan; a zero-id arm is answered without a scan.
// A two-entry queue takes new commands while a scan runs.
// Reset is synchronous on i_rst_n, clears time and the armed and used flags,
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module one_shot_timer_table_unit
    import otmt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic  q_valid;
    t_work q_item;
    logic  q_pop;

    otmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    otmt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

/* test/one_shot_timer_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_table_unit_tb: self-checking bench for the one-shot timer table
// Drives arm and tick commands through the input channel and predicts every
// status and expiry result from a behavioral copy of the timer table. Each
// output transfer is checked field by field against the oldest prediction.
// Directed tests cover rejected ids, quiet ticks, zero timeouts, every id
// expiring on one tick, and reuse of fired slots. Random traffic then runs
// mostly stalling the receiver, then mostly idling the sender, then neither.
// ----------------------------------------------------------------------------
module one_shot_timer_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import otmt_pkg::*;

    localparam int NSLOT          = SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = NSLOT + 8;
    localparam int MAX_SHOWN      = 100;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int err_cnt       = 0;
    int quiet_cycles  = 0;

    logic [TIME_W-1:0] now_ticks;
    logic              slot_live[NSLOT];
    logic [ID_W-1:0]   slot_owner_id[NSLOT];
    logic [TIME_W-1:0] slot_due[NSLOT];
    t_out_item         expected_reports[$];

    one_shot_timer_table_unit #(
        .SLOTS(NSLOT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_timer_model();
        now_ticks = '0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_live[i]     = 1'b0;
            slot_owner_id[i] = '0;
            slot_due[i]      = '0;
        end
    endfunction

    function automatic void predict_timer_results(input t_in_item item);
        t_out_item         r;
        int                hit;
        int                expired[$];
        logic [TIME_W-1:0] age;
        r = '0;
        if (item.command == CMD_ARM) begin
            r.kind = KIND_ARM;
            r.last = 1'b1;
            hit    = -1;
            if (item.client_id == '0) begin
                r.status = STAT_BAD_ID;
            end else begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (hit < 0 && slot_owner_id[i] == item.client_id) hit = i;
                end
                for (int i = 0; i < NSLOT; i++) begin
                    if (hit < 0 && !slot_live[i]) hit = i;
                end
                if (hit < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    slot_owner_id[hit] = item.client_id;
                    slot_live[hit]     = 1'b1;
                    slot_due[hit]      = now_ticks + TIME_W'(item.timeout);
                    r.status           = STAT_OK;
                end
            end
            expected_reports.push_back(r);
        end else begin
            now_ticks = now_ticks + TIME_W'(1);
            for (int i = 0; i < NSLOT; i++) begin
                age = now_ticks - slot_due[i];
                if (expired.size() < MAX_RESULTS && slot_live[i] && !age[TIME_W-1]) begin
                    slot_live[i] = 1'b0;
                    expired.push_back(i);
                end
            end
            foreach (expired[k]) begin
                r          = '0;
                r.kind     = KIND_FIRE;
                r.status   = STAT_OK;
                r.fired_id = slot_owner_id[expired[k]];
                r.last     = (k == expired.size() - 1);
                expected_reports.push_back(r);
            end
        end
    endfunction

    function automatic t_in_item make_cmd(input t_cmd cmd, input logic [ID_W-1:0] id,
                                          input logic [TIMEOUT_W-1:0] ticks);
        t_in_item item;
        item.command   = cmd;
        item.client_id = id;
        item.timeout   = ticks;
        return item;
    endfunction

    task automatic send_command(input t_in_item item);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        predict_timer_results(item);
    endtask

    task automatic test_zero_id_and_quiet_tick();
        send_command(make_cmd(CMD_ARM, '0, '1));
        send_command(make_cmd(CMD_TICK, '1, '1));
        send_command(make_cmd(CMD_ARM, '0, '0));
    endtask

    task automatic test_every_id_expires();
        for (int id = 15; id >= 1; id--) begin
            send_command(make_cmd(CMD_ARM, ID_W'(id), '0));
        end
        send_command(make_cmd(CMD_TICK, '0, '0));
    endtask

    task automatic test_slot_reuse();
        send_command(make_cmd(CMD_ARM, 4'd15, 16'd1));
        send_command(make_cmd(CMD_ARM, 4'd9, '1));
        send_command(make_cmd(CMD_ARM, 4'd9, '0));
        send_command(make_cmd(CMD_TICK, 4'd5, 16'h5A5A));
    endtask

    // With sixteen slots and fifteen nonzero ids the table never fills, so
    // most arms use short timeouts to keep slots turning over.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
        t_in_item item;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (count) begin
            item.client_id = ID_W'($urandom_range(15));
            item.timeout   = TIMEOUT_W'($urandom_range(16'hFFFF));
            item.command   = ($urandom_range(99) < 55) ? CMD_ARM : CMD_TICK;
            if (item.command == CMD_ARM) begin
                if ($urandom_range(9) == 0) begin
                    item.client_id = '0;
                end else begin
                    item.client_id = ID_W'($urandom_range(15, 1));
                end
                case ($urandom_range(9))
                    0: ;
                    1, 2: item.timeout = TIMEOUT_W'($urandom_range(64));
                    default: item.timeout = TIMEOUT_W'($urandom_range(8));
                endcase
            end
            send_command(item);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            if (err_cnt < MAX_SHOWN) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                if (err_cnt < MAX_SHOWN) begin
                    $error("result transfer with nothing expected: %p", o_data);
                end
                err_cnt++;
            end else begin
                want = expected_reports.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_data.kind));
                check_field("status", 8'(want.status), 8'(o_data.status));
                check_field("fired_id", 8'(want.fired_id), 8'(o_data.fired_id));
                check_field("last", 8'(want.last), 8'(o_data.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL one_shot_timer_table_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_timer_model();
        snd_idle_pct  = 17;
        rcv_stall_pct = 76;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_id_and_quiet_tick();
        test_every_id_expires();
        test_slot_reuse();
        test_random_traffic(17, 76, 130);
        test_random_traffic(76, 17, 130);
        test_random_traffic(0, 0, 140);
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS one_shot_timer_table_unit");
        end else begin
            $display("FAIL one_shot_timer_table_unit");
        end
        $finish;
    end

endmodule
